### hw/rtl/oswbm_pkg.sv
// Package: constants, types and the sparse code table of the watermark base mapper.
`timescale 1ns / 1ps
package oswbm_pkg;

    localparam int GROUPS     = 47;
    localparam int UPPER_SYMS = 4 * GROUPS;
    localparam int LOWER_SYMS = 5 * GROUPS;
    localparam int OLIGO_SYMS = UPPER_SYMS + LOWER_SYMS;

    localparam int POS_W      = $clog2(OLIGO_SYMS);
    localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SPARSE_W   = 5;
    localparam int CODE_W     = SPARSE_W + 1;
    localparam int SUB_W      = 3;
    localparam int SYM_W      = 2;
    localparam int BASE_W     = 3;
    localparam int BPOS_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int WM3_W      = 43;
    localparam int WM_W       = 4 * CFG_DATA_W;

    localparam logic [SUB_W-1:0]  SUB_LAST    = SUB_W'(SPARSE_W - 1);
    localparam logic [CODE_W-1:0] CODE_ERASED = CODE_W'(1) << SPARSE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WM0 = 2'd0,
        CFG_WM1 = 2'd1,
        CFG_WM2 = 2'd2,
        CFG_WM3 = 2'd3
    } t_cfg_idx;

    typedef enum logic [BASE_W-1:0] {
        BASE_A = 3'd0,
        BASE_T = 3'd1,
        BASE_G = 3'd2,
        BASE_C = 3'd3,
        BASE_N = 3'd4
    } t_base;

    typedef struct packed {
        logic              valid;
        logic              is_bit;
        logic              bit_val;
        logic              wm;
        logic [SUB_W-1:0]  sub;
        logic [BPOS_W-1:0] bpos;
        logic              last;
    } t_lane;

    function automatic logic [SPARSE_W-1:0] sparse_code(input logic [3:0] nib);
        logic [SPARSE_W-1:0] c;
        case (nib)
            4'd7:    c = 5'h18;
            4'd11:   c = 5'h14;
            4'd13:   c = 5'h12;
            4'd14:   c = 5'h11;
            4'd15:   c = 5'h10;
            default: c = {1'b0, nib};
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/oswbm_sym_if.sv
// Interface: symbol input channel.
`timescale 1ns / 1ps
interface oswbm_sym_if
    import oswbm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

### hw/rtl/oswbm_base_if.sv
// Interface: base output channel.
`timescale 1ns / 1ps
interface oswbm_base_if
    import oswbm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base;
    logic [BPOS_W-1:0] base_position;
    logic              last_base;

    modport source (output valid, output base, output base_position, output last_base,
                    input ready);
    modport sink   (input valid, input base, input base_position, input last_base,
                    output ready);
endinterface

### hw/rtl/oswbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module oswbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/oswbm_seq.sv
// Position sequencer: nibble assembly, code writes, code reads and the lane register.
`timescale 1ns / 1ps
module oswbm_seq
    import oswbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_advance,
    input  logic [WM_W-1:0]   i_wm,
    output logic              o_we,
    output logic [GRP_W-1:0]  o_waddr,
    output logic [CODE_W-1:0] o_wdata,
    output logic              o_re,
    output logic [GRP_W-1:0]  o_raddr,
    output t_lane             o_lane
);
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [3:0]        r_nib, n_nib;
    logic              r_ers, n_ers;
    logic [GRP_W-1:0]  r_grp, n_grp;
    logic [SUB_W-1:0]  r_sub, n_sub;
    logic [BPOS_W-1:0] r_bpos, n_bpos;
    logic              r_valid, n_valid;
    t_lane             r_lane, n_lane;

    logic              is_bit;
    logic              upper;
    logic [3:0]        nib_in;
    logic              ers_in;

    always_comb begin
        is_bit  = !i_symbol[1];
        upper   = (r_pos < POS_W'(UPPER_SYMS));
        nib_in  = {r_nib[2:0], is_bit & i_symbol[0]};
        ers_in  = r_ers | !is_bit;

        o_we    = i_accept && upper && (r_pos[1:0] == 2'd3);
        o_waddr = r_pos[GRP_W+1:2];
        o_wdata = ers_in ? CODE_ERASED : {1'b0, sparse_code(nib_in)};
        o_re    = i_accept && !upper;
        o_raddr = r_grp;

        n_pos   = r_pos;
        n_nib   = r_nib;
        n_ers   = r_ers;
        n_grp   = r_grp;
        n_sub   = r_sub;
        n_bpos  = r_bpos;
        n_valid = i_advance ? 1'b0 : r_valid;
        n_lane  = r_lane;

        if (i_accept) begin
            n_valid = !upper;
            if (upper) begin
                if (r_pos[1:0] == 2'd3) begin
                    n_nib = '0;
                    n_ers = 1'b0;
                end else begin
                    n_nib = nib_in;
                    n_ers = ers_in;
                end
            end else begin
                n_lane.is_bit  = is_bit;
                n_lane.bit_val = i_symbol[0];
                n_lane.wm      = i_wm[r_bpos];
                n_lane.sub     = r_sub;
                n_lane.bpos    = r_bpos;
                n_lane.last    = (r_bpos == BPOS_W'(LOWER_SYMS - 1));
                n_bpos         = r_bpos + BPOS_W'(1);
                if (r_sub == SUB_LAST) begin
                    n_sub = '0;
                    n_grp = r_grp + GRP_W'(1);
                end else begin
                    n_sub = r_sub + SUB_W'(1);
                end
            end
            if (r_pos == POS_W'(OLIGO_SYMS - 1)) begin
                n_pos  = '0;
                n_grp  = '0;
                n_sub  = '0;
                n_bpos = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
        n_lane.valid = n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_nib   <= '0;
            r_ers   <= 1'b0;
            r_grp   <= '0;
            r_sub   <= '0;
            r_bpos  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_nib   <= n_nib;
            r_ers   <= n_ers;
            r_grp   <= n_grp;
            r_sub   <= n_sub;
            r_bpos  <= n_bpos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    always_comb begin
        o_lane       = r_lane;
        o_lane.valid = r_valid;
    end
endmodule

### hw/rtl/oswbm_base.sv
// Base stage: sparse bit pick, watermark XOR, base coding and the output register.
`timescale 1ns / 1ps
module oswbm_base
    import oswbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane             i_lane,
    input  logic [CODE_W-1:0] i_code,
    input  logic              i_out_ready,
    output logic              o_advance,
    output logic              o_valid,
    output logic [BASE_W-1:0] o_base,
    output logic [BPOS_W-1:0] o_base_position,
    output logic              o_last_base
);
    logic              r_valid, n_valid;
    logic [BASE_W-1:0] r_base, n_base;
    logic [BPOS_W-1:0] r_bpos;
    logic              r_last;

    logic [SPARSE_W-1:0] sparse;
    logic                up_bit;
    logic                load;

    always_comb begin
        o_advance = !r_valid || i_out_ready;
        load      = o_advance && i_lane.valid;
        sparse    = i_code[SPARSE_W-1:0];
        up_bit    = sparse[SUB_LAST - i_lane.sub] ^ i_lane.wm;
        if (i_code[SPARSE_W] || !i_lane.is_bit) begin
            n_base = BASE_N;
        end else begin
            n_base = {1'b0, up_bit, i_lane.bit_val};
        end
        n_valid = o_advance ? i_lane.valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_base <= n_base;
            r_bpos <= i_lane.bpos;
            r_last <= i_lane.last;
        end
    end

    assign o_valid         = r_valid;
    assign o_base          = r_base;
    assign o_base_position = r_bpos;
    assign o_last_base     = r_last;
endmodule

### hw/rtl/oligo_sparse_watermark_base_mapper.sv
// Top level: watermark registers, sequencer, sparse code RAM and base stage.
// A lower symbol passes the lane register and the code RAM read register, then the base output register.
// Throughput: one symbol per cycle unless the output stalls; upper symbols give no word, lower ones give one.
// The registered code RAM read sits between the sequencer and the base stage.
// Reset clears the position counters, nibble state, pipeline valids and watermark words.
// The code RAM is not cleared: each group is written before any base reads it.
`timescale 1ns / 1ps
module oligo_sparse_watermark_base_mapper
    import oswbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    oswbm_sym_if.sink             i_sym_ch,
    oswbm_base_if.source          o_base_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [CFG_DATA_W-1:0] r_wm0, r_wm1, r_wm2;
    logic [WM3_W-1:0]      r_wm3;
    logic [WM_W-1:0]       wm_vec;

    logic              accept;
    logic              advance;
    logic              we, re;
    logic [GRP_W-1:0]  waddr, raddr;
    logic [CODE_W-1:0] wdata, rdata;
    t_lane             lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm0 <= '0;
            r_wm1 <= '0;
            r_wm2 <= '0;
            r_wm3 <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WM0: r_wm0 <= i_cfg_data;
                CFG_WM1: r_wm1 <= i_cfg_data;
                CFG_WM2: r_wm2 <= i_cfg_data;
                CFG_WM3: r_wm3 <= i_cfg_data[WM3_W-1:0];
                default: ;
            endcase
        end
    end

    assign wm_vec = {{(CFG_DATA_W - WM3_W){1'b0}}, r_wm3, r_wm2, r_wm1, r_wm0};

    assign i_sym_ch.ready = !lane.valid || advance;
    assign accept         = i_sym_ch.valid && i_sym_ch.ready;

    oswbm_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_symbol  (i_sym_ch.symbol),
        .i_advance (advance),
        .i_wm      (wm_vec),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_re      (re),
        .o_raddr   (raddr),
        .o_lane    (lane)
    );

    oswbm_ram #(
        .WIDTH (CODE_W),
        .DEPTH (GROUPS)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    oswbm_base u_base (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_lane          (lane),
        .i_code          (rdata),
        .i_out_ready     (o_base_ch.ready),
        .o_advance       (advance),
        .o_valid         (o_base_ch.valid),
        .o_base          (o_base_ch.base),
        .o_base_position (o_base_ch.base_position),
        .o_last_base     (o_base_ch.last_base)
    );

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_base_ch.valid && o_base_ch.last_base
            |-> o_base_ch.base_position == BPOS_W'(LOWER_SYMS - 1))
        else $error("last_base away from the final position");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sym_ch.ready |-> o_base_ch.valid && !o_base_ch.ready && lane.valid)
        else $error("input stalled without a full pipeline");

    a_base_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_base_ch.valid |-> o_base_ch.base <= BASE_N)
        else $error("base code out of range");

    a_lane_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane.valid && advance |=> o_base_ch.valid)
        else $error("lane word lost on advance");
endmodule

### test/oligo_sparse_watermark_base_mapper_test.sv
// Testbench: streams oligos through the watermark base mapper and checks every base word.
`timescale 1ns / 1ps
module oligo_sparse_watermark_base_mapper_test;
    import oswbm_pkg::*;

    localparam logic [SYM_W-1:0] SYM_ZERO   = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ONE    = 2'd1;
    localparam logic [SYM_W-1:0] SYM_ERASED = 2'd2;
    localparam logic [SYM_W-1:0] SYM_THREE  = 2'd3;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int MAX_REPORTS    = 40;
    localparam int RAND_OLIGOS    = 2;
    localparam int SCRIPT_LEN     = 10;

    localparam logic [SPARSE_W-1:0] SPARSE_LUT [16] = '{
        5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h06, 5'h18,
        5'h08, 5'h09, 5'h0A, 5'h14, 5'h0C, 5'h12, 5'h11, 5'h10
    };

    typedef enum {SEG_FILL, SEG_RAMP, SEG_WM} t_seg_kind;

    typedef struct {
        t_seg_kind              kind;
        logic [SYM_W-1:0]       sym;
        int                     count;
        logic [CFG_DATA_W-1:0]  pattern;
        bit                     typed;
        t_base                  base;
    } t_seg;

    typedef struct packed {
        t_base             base;
        logic [BPOS_W-1:0] bpos;
        logic              last;
    } t_base_word;

    // Directed oligos: all-zero after reset, then erased groups and a nibble ramp under a full
    // watermark.
    t_seg script [SCRIPT_LEN] = '{
        '{SEG_FILL, SYM_ZERO,   UPPER_SYMS,       64'h0, 1'b0, BASE_A},
        '{SEG_FILL, SYM_ZERO,   LOWER_SYMS,       64'h0, 1'b1, BASE_A},
        '{SEG_WM,   SYM_ZERO,   0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, BASE_A},
        '{SEG_FILL, SYM_ZERO,   3,                64'h0, 1'b0, BASE_A},
        '{SEG_FILL, SYM_ERASED, 1,                64'h0, 1'b0, BASE_A},
        '{SEG_FILL, SYM_ONE,    3,                64'h0, 1'b0, BASE_A},
        '{SEG_FILL, SYM_THREE,  1,                64'h0, 1'b0, BASE_A},
        '{SEG_RAMP, SYM_ZERO,   UPPER_SYMS - 8,   64'h0, 1'b0, BASE_A},
        '{SEG_FILL, SYM_ONE,    100,              64'h0, 1'b0, BASE_A},
        '{SEG_FILL, SYM_THREE,  LOWER_SYMS - 100, 64'h0, 1'b1, BASE_N}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  typed_on;
    t_base                 typed_base;

    oswbm_sym_if  sym_ch ();
    oswbm_base_if base_ch ();

    oligo_sparse_watermark_base_mapper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sym_ch   (sym_ch),
        .o_base_ch  (base_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    logic [CFG_DATA_W-1:0] wm_words [4];
    int                    sym_pos;
    logic [3:0]            nibble;
    logic                  nib_erased;
    logic [CODE_W-1:0]     group_codes [GROUPS];
    t_base_word            bases_due [$];
    int                    errors = 0;
    int                    quiet = 0;
    bit                    idling = 1'b1;
    bit                    hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic watermark_at(input int p);
        int w;
        w = p / CFG_DATA_W;
        if (w >= 4) return 1'b0;
        return wm_words[w][p % CFG_DATA_W];
    endfunction

    function automatic bit map_symbol(input logic [SYM_W-1:0] sym, output t_base_word res);
        logic              is_bit;
        logic              up;
        logic [CODE_W-1:0] code;
        int                p;
        int                g;
        int                j;
        bit                hit;
        hit = 1'b0;
        res = '0;
        is_bit = (sym == SYM_ZERO) || (sym == SYM_ONE);
        if (sym_pos < UPPER_SYMS) begin
            nibble = {nibble[2:0], is_bit & sym[0]};
            if (!is_bit) nib_erased = 1'b1;
            if (sym_pos % 4 == 3) begin
                group_codes[sym_pos / 4] = nib_erased ? CODE_ERASED
                                                      : {1'b0, SPARSE_LUT[nibble]};
                nibble = '0;
                nib_erased = 1'b0;
            end
        end else begin
            p = sym_pos - UPPER_SYMS;
            g = p / SPARSE_W;
            j = p % SPARSE_W;
            code = group_codes[g];
            if ((code & CODE_ERASED) != '0 || !is_bit) begin
                res.base = BASE_N;
            end else begin
                up = code[SPARSE_W - 1 - j] ^ watermark_at(p);
                res.base = t_base'({1'b0, up, sym[0]});
            end
            res.bpos = p[BPOS_W-1:0];
            res.last = (p == LOWER_SYMS - 1);
            hit = 1'b1;
        end
        sym_pos = (sym_pos + 1) % OLIGO_SYMS;
        return hit;
    endfunction

    always @(posedge i_clk) begin : check_words
        t_base_word want;
        t_base_word got;
        if (!i_rst_n) begin
            foreach (wm_words[k]) wm_words[k] = '0;
            sym_pos = 0;
            nibble = '0;
            nib_erased = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_WM0: wm_words[CFG_WM0] = cfg_data;
                    CFG_WM1: wm_words[CFG_WM1] = cfg_data;
                    CFG_WM2: wm_words[CFG_WM2] = cfg_data;
                    CFG_WM3: wm_words[CFG_WM3] = CFG_DATA_W'(cfg_data[WM3_W-1:0]);
                    default: ;
                endcase
            end
            if (sym_ch.valid && sym_ch.ready && map_symbol(sym_ch.symbol, want)) begin
                if (typed_on) want.base = typed_base;
                bases_due.insert(bases_due.size(), want);
            end
            if (base_ch.valid && base_ch.ready) begin
                got.base = t_base'(base_ch.base);
                got.bpos = base_ch.base_position;
                got.last = base_ch.last_base;
                if (bases_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: base word: expected none, actual base %0d pos %0d last %0b",
                                 $time, got.base, got.bpos, got.last);
                end else begin
                    want = bases_due.pop_front();
                    if (got.base !== want.base) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: pos %0d base: expected %0d, actual %0d",
                                     $time, want.bpos, want.base, got.base);
                    end
                    if (got.bpos !== want.bpos) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: base_position: expected %0d, actual %0d",
                                     $time, want.bpos, got.bpos);
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: pos %0d last_base: expected %0b, actual %0b",
                                     $time, want.bpos, want.last, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (sym_ch.valid && sym_ch.ready) || (base_ch.valid && base_ch.ready)
                || cfg_we) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        base_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                base_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idling && $urandom_range(0, 5) == 0) begin
                base_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                base_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input bit typed, input t_base tb);
        if (idling && $urandom_range(0, 7) == 0) begin
            sym_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        sym_ch.valid  <= 1'b1;
        sym_ch.symbol <= sym;
        typed_on      <= typed;
        typed_base    <= tb;
        do @(posedge i_clk); while (!sym_ch.ready);
    endtask

    task automatic wait_drained();
        sym_ch.valid <= 1'b0;
        do @(posedge i_clk); while (bases_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_watermark(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                                 input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3);
        t_cfg_idx              regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_WM0, CFG_WM1, CFG_WM2, CFG_WM3};
        vals = '{w0, w1, w2, w3};
        for (int k = 0; k < 4; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[k];
            cfg_data <= vals[k];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_watermark();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [3:0]       ramp_nib;
        logic [SYM_W-1:0] sym;
        int               thr;
        int               pad_from;
        i_rst_n       <= 1'b0;
        sym_ch.valid  <= 1'b0;
        sym_ch.symbol <= SYM_ZERO;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_WM0;
        cfg_data      <= '0;
        typed_on      <= 1'b0;
        typed_base    <= BASE_A;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            case (script[r].kind)
                SEG_WM: begin
                    wait_drained();
                    set_watermark(script[r].pattern, script[r].pattern,
                                  script[r].pattern, script[r].pattern);
                end
                SEG_RAMP: begin
                    for (int i = 0; i < script[r].count; i++) begin
                        ramp_nib = 4'((i / 4) % 16);
                        send_symbol(ramp_nib[3 - i % 4] ? SYM_ONE : SYM_ZERO, 1'b0, BASE_A);
                    end
                end
                default: begin
                    repeat (script[r].count)
                        send_symbol(script[r].sym, script[r].typed, script[r].base);
                end
            endcase
        end

        for (int k = 0; k < RAND_OLIGOS; k++) begin
            wait_drained();
            set_watermark(pick_watermark(), pick_watermark(), pick_watermark(),
                          pick_watermark());
            idling = (k < RAND_OLIGOS - 1);
            case ($urandom_range(0, 3))
                0:       thr = 0;
                1:       thr = 2;
                2:       thr = 16;
                default: thr = 128;
            endcase
            pad_from = ($urandom_range(0, 3) == 0) ? $urandom_range(0, OLIGO_SYMS - 1)
                                                   : OLIGO_SYMS;
            for (int i = 0; i < OLIGO_SYMS; i++) begin
                if (k == 0 && i == 150) hold_req = 1'b1;
                if (i >= pad_from)
                    sym = SYM_ERASED;
                else if ($urandom_range(0, 255) < thr)
                    sym = $urandom_range(0, 1) ? SYM_ERASED : SYM_THREE;
                else
                    sym = $urandom_range(0, 1) ? SYM_ONE : SYM_ZERO;
                send_symbol(sym, 1'b0, BASE_A);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/oswbm_pkg.sv
hw/rtl/oswbm_sym_if.sv
hw/rtl/oswbm_base_if.sv
hw/rtl/oswbm_ram.sv
hw/rtl/oswbm_seq.sv
hw/rtl/oswbm_base.sv
hw/rtl/oligo_sparse_watermark_base_mapper.sv
test/oligo_sparse_watermark_base_mapper_test.sv
